// File: rtl/alpe_pkg.sv
// ----------------------------------------------------------------------------
// alpe_pkg: shared types and constants of the LED pulse encoder
// Register indexes, reset values, payload structs and the job record that
// travels from the front end to the serializer.
// ----------------------------------------------------------------------------
package alpe_pkg;

	localparam int MAX_HEADER_BITS = 16;
	localparam int HDR_CNT_W       = 5;
	localparam int POS_W           = 16;
	localparam int COLOUR_BITS     = 24;
	localparam int COL_CNT_W       = 5;
	localparam int CFG_INDEX_W     = 3;
	localparam int CFG_DATA_W      = 9;
	localparam int TIME_W          = 8;
	localparam int ORDER_W         = 9;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_BIT_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOUR_ORDER     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH_TIME    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH_TIME   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BIT_LOW_TIME     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FOOTER_TIME      = 3'd5;

	// Reset values.
	localparam logic [HDR_CNT_W-1:0] RST_HEADER_BIT_COUNT = 5'd0;
	localparam logic [ORDER_W-1:0]   RST_COLOUR_ORDER     = 9'd66;
	localparam logic [TIME_W-1:0]    RST_ONE_HIGH_TIME    = 8'd135;
	localparam logic [TIME_W-1:0]    RST_ZERO_HIGH_TIME   = 8'd80;
	localparam logic [TIME_W-1:0]    RST_BIT_LOW_TIME     = 8'd80;
	localparam logic [TIME_W-1:0]    RST_FOOTER_TIME      = 8'd250;

	// Byte selector values above this pick a zero byte.
	localparam logic [2:0] SEL_LAST_BYTE = 3'd3;

	typedef struct packed {
		logic [HDR_CNT_W-1:0] header_bit_count;
		logic [ORDER_W-1:0]   colour_order;
		logic [TIME_W-1:0]    one_high_time;
		logic [TIME_W-1:0]    zero_high_time;
		logic [TIME_W-1:0]    bit_low_time;
		logic [TIME_W-1:0]    footer_time;
	} cfg_t;

	typedef struct packed {
		logic       frame_start;
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
	} in_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] high_time;
		logic [TIME_W-1:0] low_time;
		logic              last_pulse;
	} out_item_t;

	// One LED's work: header bits, position and the colour bits in send order.
	typedef struct packed {
		logic [HDR_CNT_W-1:0]   hdr_count;
		logic [POS_W-1:0]       position;
		logic [COLOUR_BITS-1:0] colour;
	} job_t;

endpackage

// File: rtl/addressed_led_pulse_encoder_core.sv
// ----------------------------------------------------------------------------
// addressed_led_pulse_encoder_core: addressable LED bit pulse encoder
// Turns one LED's colour bytes into a run of high/low pulse beats.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries one LED's four colour bytes and a frame start flag.
// The block answers with header_bit_count (at most 16) position bits, then
// 24 colour bits in the order set by colour_order, then one footer beat
// with last_pulse set. Each output beat holds a high and a low time.
// A serializer emits one pulse beat per cycle while the receiver takes them,
// so an LED spans min(header_bit_count, 16) + 25 beats; that serializer sets the rate.
// When idle, an LED's first pulse goes via the queue, serializer and output
// registers. A two-entry job queue lets up to two further LEDs be
// accepted while the serializer is busy or the receiver stalls; a stalled
// receiver simply holds the output register and the serializer waits.
// Configuration writes are taken in any cycle (cfg_ready is tied high) and
// are meant to be made while the block is idle. Reset restores the default
// register values, empties the queue and restarts the LED position at 0.
// ----------------------------------------------------------------------------
module addressed_led_pulse_encoder_core
	import alpe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_data
);

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_bit_count <= RST_HEADER_BIT_COUNT;
			cfg_q.colour_order     <= RST_COLOUR_ORDER;
			cfg_q.one_high_time    <= RST_ONE_HIGH_TIME;
			cfg_q.zero_high_time   <= RST_ZERO_HIGH_TIME;
			cfg_q.bit_low_time     <= RST_BIT_LOW_TIME;
			cfg_q.footer_time      <= RST_FOOTER_TIME;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HEADER_BIT_COUNT: cfg_q.header_bit_count <= cfg_data[HDR_CNT_W-1:0];
				REG_COLOUR_ORDER:     cfg_q.colour_order     <= cfg_data[ORDER_W-1:0];
				REG_ONE_HIGH_TIME:    cfg_q.one_high_time    <= cfg_data[TIME_W-1:0];
				REG_ZERO_HIGH_TIME:   cfg_q.zero_high_time   <= cfg_data[TIME_W-1:0];
				REG_BIT_LOW_TIME:     cfg_q.bit_low_time     <= cfg_data[TIME_W-1:0];
				REG_FOOTER_TIME:      cfg_q.footer_time      <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	alpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	alpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	alpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: rtl/alpe_front.sv
// ----------------------------------------------------------------------------
// alpe_front: input front end
// Numbers each LED, clamps the header length and puts the three selected
// colour bytes into send order, then hands the job to the queue.
// ----------------------------------------------------------------------------
module alpe_front
	import alpe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     push_valid,
	input  logic     push_ready,
	output job_t     push_data
);

	logic [POS_W-1:0] led_position_q;
	logic [POS_W-1:0] pos;
	logic [7:0]       first_byte;
	logic [7:0]       second_byte;
	logic [7:0]       third_byte;

	function automatic logic [7:0] pick_byte(input logic [2:0] sel, input in_item_t item);
		logic [7:0] res;
		case (sel)
			3'd0:    res = item.byte_zero;
			3'd1:    res = item.byte_one;
			3'd2:    res = item.byte_two;
			SEL_LAST_BYTE: res = item.byte_three;
			default: res = 8'd0;
		endcase
		return res;
	endfunction

	assign pos         = in_data.frame_start ? '0 : led_position_q;
	assign first_byte  = pick_byte(cfg.colour_order[8:6], in_data);
	assign second_byte = pick_byte(cfg.colour_order[5:3], in_data);
	assign third_byte  = pick_byte(cfg.colour_order[2:0], in_data);

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		push_data.position = pos;
		// The first byte sits in the low bits since bits leave LSB first.
		push_data.colour   = {third_byte, second_byte, first_byte};
		if (cfg.header_bit_count > HDR_CNT_W'(MAX_HEADER_BITS)) begin
			push_data.hdr_count = HDR_CNT_W'(MAX_HEADER_BITS);
		end else begin
			push_data.hdr_count = cfg.header_bit_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_position_q <= '0;
		end else if (in_valid && push_ready) begin
			led_position_q <= pos + POS_W'(1);
		end
	end

endmodule

// File: rtl/alpe_queue.sv
// ----------------------------------------------------------------------------
// alpe_queue: two-entry job queue
// Decouples the front end from the serializer so each side stalls on its own.
// ----------------------------------------------------------------------------
module alpe_queue
	import alpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/alpe_back.sv
// ----------------------------------------------------------------------------
// alpe_back: pulse serializer
// Shifts out the header bits, then the colour bits, then the footer mark,
// one pulse beat per cycle unless the receiver stalls, into a registered output.
// ----------------------------------------------------------------------------
module alpe_back
	import alpe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  job_t      pop_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic                   busy_q;
	logic [HDR_CNT_W-1:0]   hdr_left_q;
	logic [COL_CNT_W-1:0]   col_left_q;
	logic [POS_W-1:0]       pos_q;
	logic [COLOUR_BITS-1:0] col_q;
	logic                   out_valid_q;
	out_item_t              out_data_q;
	logic                   emit;
	logic                   is_footer;
	logic                   load;
	logic                   data_bit;

	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign is_footer = (hdr_left_q == '0) && (col_left_q == '0);
	// The next job is taken in the same cycle the footer leaves.
	assign pop_ready = !busy_q || (emit && is_footer);
	assign load      = pop_valid && pop_ready;
	assign data_bit  = (hdr_left_q != '0) ? pos_q[0] : col_q[0];

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			hdr_left_q  <= '0;
			col_left_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (load) begin
				busy_q     <= 1'b1;
				hdr_left_q <= pop_data.hdr_count;
				col_left_q <= COL_CNT_W'(COLOUR_BITS);
			end else if (emit) begin
				if (is_footer) begin
					busy_q <= 1'b0;
				end else if (hdr_left_q != '0) begin
					hdr_left_q <= hdr_left_q - HDR_CNT_W'(1);
				end else begin
					col_left_q <= col_left_q - COL_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (is_footer) begin
				out_data_q.high_time  <= cfg.footer_time;
				out_data_q.low_time   <= cfg.footer_time;
				out_data_q.last_pulse <= 1'b1;
			end else begin
				out_data_q.high_time  <= data_bit ? cfg.one_high_time : cfg.zero_high_time;
				out_data_q.low_time   <= cfg.bit_low_time;
				out_data_q.last_pulse <= 1'b0;
			end
		end

		if (load) begin
			pos_q <= pop_data.position;
			col_q <= pop_data.colour;
		end else if (emit && !is_footer) begin
			if (hdr_left_q != '0) begin
				pos_q <= pos_q >> 1;
			end else begin
				col_q <= col_q >> 1;
			end
		end
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for addressed_led_pulse_encoder_core
// LED colour beats go in through a bursty sender while the pulse output is
// drained by a receiver that stalls in changing patterns. A scoreboard class
// predicts the pulse run of every accepted LED from its own copy of the
// registers and the LED position, and compares each output beat in order.
// Directed LEDs cover the field extremes and the register corner cases, and
// random LEDs run under several random register settings.
// ----------------------------------------------------------------------------
module testbench;
	import alpe_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = 8;
	localparam int RUN_LIMIT_NS  = 5_000_000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_LEDS    = 39;

	// No register sits at this index; writes to it must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNASSIGNED = 3'd7;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_e;

	class led_pulse_scoreboard;
		cfg_t              regs;
		logic [POS_W-1:0]  next_position;
		out_item_t         pending_pulses[$];
		int unsigned       failures;

		function new();
			regs.header_bit_count = RST_HEADER_BIT_COUNT;
			regs.colour_order     = RST_COLOUR_ORDER;
			regs.one_high_time    = RST_ONE_HIGH_TIME;
			regs.zero_high_time   = RST_ZERO_HIGH_TIME;
			regs.bit_low_time     = RST_BIT_LOW_TIME;
			regs.footer_time      = RST_FOOTER_TIME;
			next_position         = '0;
			failures              = 0;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] index,
				logic [CFG_DATA_W-1:0] value);
			case (index)
				REG_HEADER_BIT_COUNT: regs.header_bit_count = value[HDR_CNT_W-1:0];
				REG_COLOUR_ORDER:     regs.colour_order     = value[ORDER_W-1:0];
				REG_ONE_HIGH_TIME:    regs.one_high_time    = value[TIME_W-1:0];
				REG_ZERO_HIGH_TIME:   regs.zero_high_time   = value[TIME_W-1:0];
				REG_BIT_LOW_TIME:     regs.bit_low_time     = value[TIME_W-1:0];
				REG_FOOTER_TIME:      regs.footer_time      = value[TIME_W-1:0];
				default: ;
			endcase
		endfunction

		function void push_bit(logic one);
			out_item_t pulse;
			pulse.high_time  = one ? regs.one_high_time : regs.zero_high_time;
			pulse.low_time   = regs.bit_low_time;
			pulse.last_pulse = 1'b0;
			pending_pulses.push_back(pulse);
		endfunction

		function void note_led(in_item_t led);
			logic [7:0]       colour [4];
			logic [POS_W-1:0] position;
			logic [2:0]       sel;
			logic [7:0]       value;
			out_item_t        footer;
			int               header_bits;
			colour[0] = led.byte_zero;
			colour[1] = led.byte_one;
			colour[2] = led.byte_two;
			colour[3] = led.byte_three;
			position = led.frame_start ? '0 : next_position;
			header_bits = (regs.header_bit_count > MAX_HEADER_BITS) ?
				MAX_HEADER_BITS : int'(regs.header_bit_count);
			for (int b = 0; b < header_bits; b++)
				push_bit((b < POS_W) ? position[b] : 1'b0);
			// The top selector field picks the byte that goes out first.
			for (int field = 2; field >= 0; field--) begin
				sel = regs.colour_order[field*3 +: 3];
				value = (sel <= SEL_LAST_BYTE) ? colour[sel[1:0]] : 8'h00;
				for (int f = 0; f < 8; f++)
					push_bit(value[f]);
			end
			footer.high_time  = regs.footer_time;
			footer.low_time   = regs.footer_time;
			footer.last_pulse = 1'b1;
			pending_pulses.push_back(footer);
			next_position = position + 1'b1;
		endfunction

		function void check_pulse(out_item_t got);
			out_item_t want;
			if (pending_pulses.size() == 0) begin
				$error("unexpected pulse beat: high %0d low %0d last %0b",
					got.high_time, got.low_time, got.last_pulse);
				failures++;
				return;
			end
			want = pending_pulses.pop_front();
			if (got.high_time !== want.high_time) begin
				$error("high_time: expected %0d, got %0d", want.high_time, got.high_time);
				failures++;
			end
			if (got.low_time !== want.low_time) begin
				$error("low_time: expected %0d, got %0d", want.low_time, got.low_time);
				failures++;
			end
			if (got.last_pulse !== want.last_pulse) begin
				$error("last_pulse: expected %0b, got %0b", want.last_pulse, got.last_pulse);
				failures++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	in_item_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_item_t              out_data;

	led_pulse_scoreboard pulse_board = new();

	addressed_led_pulse_encoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("testbench: FAIL");
		$finish;
	end

	// Receiver: each span of random length uses a randomly chosen stall pattern.
	initial begin : receiver
		rx_mode_e mode;
		int       span;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_e'($urandom_range(0, 2));
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
					default:   out_ready <= ($urandom_range(0, 7) == 0) ? ~out_ready : out_ready;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			pulse_board.check_pulse(out_data);
	end

	task automatic write_register(logic [CFG_INDEX_W-1:0] index,
			logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		pulse_board.write_register(index, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(logic [CFG_DATA_W-1:0] header, logic [CFG_DATA_W-1:0] order,
			logic [CFG_DATA_W-1:0] one_hi, logic [CFG_DATA_W-1:0] zero_hi,
			logic [CFG_DATA_W-1:0] bit_lo, logic [CFG_DATA_W-1:0] footer);
		write_register(REG_HEADER_BIT_COUNT, header);
		write_register(REG_COLOUR_ORDER, order);
		write_register(REG_ONE_HIGH_TIME, one_hi);
		write_register(REG_ZERO_HIGH_TIME, zero_hi);
		write_register(REG_BIT_LOW_TIME, bit_lo);
		write_register(REG_FOOTER_TIME, footer);
	endtask

	// Valid stays high after acceptance until the next beat or an explicit pause.
	task automatic send_led(in_item_t led);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= led;
		do @(posedge clk); while (!in_ready);
		pulse_board.note_led(led);
	endtask

	task automatic pause_input(int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_for_drain();
		pause_input(1);
		while (pulse_board.pending_pulses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_leds(int unsigned count, bit pause_midway);
		int unsigned sent;
		int          burst;
		in_item_t    led;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && sent < count) begin
				led.frame_start = ($urandom_range(0, 19) == 0);
				led.byte_zero   = 8'($urandom_range(0, 255));
				led.byte_one    = 8'($urandom_range(0, 255));
				led.byte_two    = 8'($urandom_range(0, 255));
				led.byte_three  = 8'($urandom_range(0, 255));
				send_led(led);
				sent++;
				burst--;
			end
			if (pause_midway && sent >= count / 2) begin
				wait_for_drain();
				pause_midway = 1'b0;
			end else if ($urandom_range(0, 3) != 0) begin
				pause_input($urandom_range(1, 10));
			end
		end
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] header;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Reset register values.
		send_led(in_item_t'{1'b1, 8'h00, 8'h00, 8'h00, 8'h00});
		send_led(in_item_t'{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_led(in_item_t'{1'b0, 8'h01, 8'h80, 8'h55, 8'hAA});
		send_led(in_item_t'{1'b0, 8'hAA, 8'h55, 8'h80, 8'h01});
		send_led(in_item_t'{1'b1, 8'h12, 8'h34, 8'h56, 8'h78});
		wait_for_drain();

		// Full header, selectors above three give zero bytes, time extremes.
		write_register(REG_UNASSIGNED, 9'h1FF);
		write_all(9'd16, 9'b111_100_011, 9'd255, 9'd1, 9'd255, 9'd1);
		send_led(in_item_t'{1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_led(in_item_t'{1'b0, 8'h0F, 8'hF0, 8'h3C, 8'hC3});
		send_led(in_item_t'{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF});
		send_led(in_item_t'{1'b0, 8'h81, 8'h42, 8'h24, 8'h18});
		wait_for_drain();

		// Header count beyond the limit and zero time values.
		write_all(9'd31, 9'b000_001_010, 9'd0, 9'd255, 9'd1, 9'd0);
		send_led(in_item_t'{1'b0, 8'hA5, 8'h5A, 8'hFF, 8'h00});
		send_led(in_item_t'{1'b1, 8'h01, 8'h02, 8'h04, 8'h08});
		send_led(in_item_t'{1'b0, 8'h10, 8'h20, 8'h40, 8'h80});
		send_led(in_item_t'{1'b0, 8'hFE, 8'hFD, 8'hFB, 8'hF7});
		wait_for_drain();

		write_all(9'd17, 9'b101_110_010, 9'd1, 9'd0, 9'd0, 9'd255);
		send_led(in_item_t'{1'b0, 8'h33, 8'hCC, 8'h99, 8'h66});
		send_led(in_item_t'{1'b0, 8'hEF, 8'hDF, 8'hBF, 8'h7F});
		send_led(in_item_t'{1'b1, 8'h77, 8'h88, 8'h11, 8'hEE});
		wait_for_drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			header = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(17, 31)) :
				CFG_DATA_W'($urandom_range(0, 16));
			write_all(header, CFG_DATA_W'($urandom_range(0, 511)),
				CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)),
				CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)));
			send_random_leds(PHASE_LEDS, phase == 2);
			wait_for_drain();
		end

		if (pulse_board.failures == 0 && pulse_board.pending_pulses.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
